// ===== rtl/rti_pkg.sv =====
package rti_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // quotient, vertex numerator and compare widths of the vertex divide
  localparam int QW  = COORD_WIDTH - 1;
  localparam int VNW = COORD_WIDTH + FRAC_BITS;
  localparam int VCW = 2 * COORD_WIDTH + FRAC_BITS;

  // edge, cross product and dot product widths
  localparam int EW  = COORD_WIDTH + 1;
  localparam int XW  = 2 * COORD_WIDTH + 3;
  localparam int LW  = COORD_WIDTH + 2;
  localparam int HW  = XW - LW;
  localparam int PLW = EW + LW + 1;
  localparam int PHW = EW + HW;
  localparam int DW  = 3 * COORD_WIDTH + 8;

  // distance divide widths
  localparam int NW = DW + FRAC_BITS;
  localparam int CW = DW + QW + 2;

  // stream packing
  localparam int VTX_W    = 4 * COORD_WIDTH - 1;
  localparam int IN_BITS  = 3 * VTX_W;
  localparam int IN_TW    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 3 + QW;
  localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

  localparam int REG_IDX_W = 3;

  localparam logic [QW-1:0] QMAX = {QW{1'b1}};
  localparam logic [COORD_WIDTH-1:0] DIR_Z_RESET = COORD_WIDTH'(400) << FRAC_BITS;

  // det * 1e6 < 2^(3F) is det < ceil(2^(3F) / 1e6)
  localparam logic [DW-1:0] EPS_RECIP = DW'(1000000);
  localparam logic [DW-1:0] ONE_3F    = DW'(1) << (3 * FRAC_BITS);
  localparam logic [DW-1:0] EPS_LIM   = (ONE_3F + EPS_RECIP - DW'(1)) / EPS_RECIP;

  typedef enum logic [2:0] {
    OUT_HIT    = 3'd0,
    OUT_CULL   = 3'd1,
    OUT_U      = 3'd2,
    OUT_V      = 3'd3,
    OUT_BEHIND = 3'd4
  } outcome_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [8:0][QW-1:0]  q;
    logic [8:0][VNW-1:0] rem;
    logic [8:0]          neg;
    logic [8:0]          sat;
    logic [2:0][QW-1:0]  den;
  } vd_t;

  typedef struct packed {
    outcome_t       oc;
    logic [QW-1:0]  q;
    logic [NW-1:0]  rem;
    logic [DW-1:0]  den;
    logic           sat;
  } dv_t;

endpackage

// ===== rtl/ray_triangle_intersect_core.sv =====
// pipeline: 32 vertex divide stages, 7 geometry stages, 32 distance divide stages,
// output register
// throughput: one triangle per cycle when not stalled; the 31-bit restoring dividers retire one
// quotient bit per stage and the wide dot-product multiplies are split into registered partials
// reset (rst_n low, synchronous): all stage valid bits and the output/skid
// valid flags clear; origin and direction return to (0,0,0) and (0,0,400)
module ray_triangle_intersect_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rti_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [rti_pkg::COORD_WIDTH-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // v0_x, v0_y, v0_z, v0_w, v1_x, v1_y, v1_z, v1_w, v2_x, v2_y, v2_z, v2_w
  input  logic [rti_pkg::IN_TW-1:0]            in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // outcome, distance
  output logic [rti_pkg::OUT_TW-1:0]           out_tdata
);

  localparam int C  = rti_pkg::COORD_WIDTH;
  localparam int F  = rti_pkg::FRAC_BITS;
  localparam int QW = rti_pkg::QW;
  localparam int EW = rti_pkg::EW;
  localparam int XW = rti_pkg::XW;
  localparam int LW = rti_pkg::LW;
  localparam int HW = rti_pkg::HW;
  localparam int DW = rti_pkg::DW;

  logic signed [C-1:0] org_r [3];
  logic signed [C-1:0] dir_r [3];

  logic en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= rti_pkg::DIR_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rti_pkg::REG_ORG_X: org_r[0] <= cfg_wdata;
        rti_pkg::REG_ORG_Y: org_r[1] <= cfg_wdata;
        rti_pkg::REG_ORG_Z: org_r[2] <= cfg_wdata;
        rti_pkg::REG_DIR_X: dir_r[0] <= cfg_wdata;
        rti_pkg::REG_DIR_Y: dir_r[1] <= cfg_wdata;
        rti_pkg::REG_DIR_Z: dir_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // vertex divide pipeline
  rti_pkg::vd_t   vd_r   [0:QW];
  rti_pkg::vd_t   vd_nxt [0:QW];
  logic [QW:0]    vdv_r;

  always_comb begin
    logic signed [C-1:0]        vx;
    logic [C-1:0]               vmag;
    logic [QW-1:0]              vw;
    logic [rti_pkg::VNW-1:0]    num;
    logic [rti_pkg::VCW-1:0]    dsh;
    for (int k = 0; k < 3; k++) begin
      vw = in_tdata[k*rti_pkg::VTX_W + 3*C +: QW];
      vd_nxt[0].den[k] = (vw == '0) ? QW'(1) : vw;
      for (int i = 0; i < 3; i++) begin
        vx   = in_tdata[k*rti_pkg::VTX_W + i*C +: C];
        vmag = vx[C-1] ? C'(~vx + 1'b1) : C'(vx);
        num  = {vmag, {F{1'b0}}};
        dsh  = rti_pkg::VCW'(vd_nxt[0].den[k]) << QW;
        vd_nxt[0].neg[3*k+i] = vx[C-1];
        vd_nxt[0].rem[3*k+i] = num;
        vd_nxt[0].q[3*k+i]   = '0;
        vd_nxt[0].sat[3*k+i] = rti_pkg::VCW'(num) >= dsh;
      end
    end
    for (int j = 1; j <= QW; j++) begin
      vd_nxt[j] = vd_r[j-1];
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          dsh = rti_pkg::VCW'(vd_r[j-1].den[k]) << (QW - j);
          if (rti_pkg::VCW'(vd_r[j-1].rem[3*k+i]) >= dsh) begin
            vd_nxt[j].rem[3*k+i] =
              rti_pkg::VNW'(rti_pkg::VCW'(vd_r[j-1].rem[3*k+i]) - dsh);
            vd_nxt[j].q[3*k+i][QW-j] = 1'b1;
          end
        end
      end
    end
  end

  // geometry stages
  logic                  b1v_r, b2v_r, b3v_r, b4v_r, b5v_r, b6v_r, b7v_r;
  logic signed [EW-1:0]  b1_e1_nxt [3], b1_e2_nxt [3], b1_tv_nxt [3];
  logic signed [EW-1:0]  b1_e1_r [3], b1_e2_r [3], b1_tv_r [3];
  logic signed [EW-1:0]  b2_e1_r [3], b2_e2_r [3], b2_tv_r [3];
  logic signed [EW-1:0]  b3_e1_r [3], b3_e2_r [3], b3_tv_r [3];
  logic signed [2*EW-1:0] px_nxt [2][3][2];
  logic signed [2*EW-1:0] px_r   [2][3][2];
  logic signed [XW-1:0]  cr_nxt [2][3];
  logic signed [XW-1:0]  cr_r   [2][3];
  logic signed [rti_pkg::PLW-1:0] pl_nxt [4][3];
  logic signed [rti_pkg::PLW-1:0] pl_r   [4][3];
  logic signed [rti_pkg::PHW-1:0] ph_nxt [4][3];
  logic signed [rti_pkg::PHW-1:0] ph_r   [4][3];
  logic signed [DW-1:0]  pr_nxt [4][3];
  logic signed [DW-1:0]  pr_r   [4][3];
  logic signed [DW-1:0]  s_nxt [4];
  logic signed [DW-1:0]  s_r   [4];
  rti_pkg::outcome_t     oc_nxt, oc_r;
  logic signed [DW-1:0]  t_r, det_r;

  always_comb begin
    logic [QW-1:0]        qq;
    logic signed [C-1:0]  ps;
    logic signed [C-1:0]  p [3][3];
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        qq = vd_r[QW].sat[3*k+i] ? rti_pkg::QMAX : vd_r[QW].q[3*k+i];
        ps = signed'({1'b0, qq});
        p[k][i] = vd_r[QW].neg[3*k+i] ? -ps : ps;
      end
    end
    for (int i = 0; i < 3; i++) begin
      b1_e1_nxt[i] = EW'(p[1][i]) - EW'(p[0][i]);
      b1_e2_nxt[i] = EW'(p[2][i]) - EW'(p[0][i]);
      b1_tv_nxt[i] = EW'(org_r[i]) - EW'(p[0][i]);
    end
  end

  // cross products: pv = dir x e2, qv = tv x e1
  always_comb begin
    int a, b;
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      px_nxt[0][i][0] = EW'(dir_r[a]) * b1_e2_r[b];
      px_nxt[0][i][1] = EW'(dir_r[b]) * b1_e2_r[a];
      px_nxt[1][i][0] = b1_tv_r[a] * b1_e1_r[b];
      px_nxt[1][i][1] = b1_tv_r[b] * b1_e1_r[a];
    end
    for (int g = 0; g < 2; g++) begin
      for (int i = 0; i < 3; i++) begin
        cr_nxt[g][i] = XW'(px_r[g][i][0]) - XW'(px_r[g][i][1]);
      end
    end
  end

  // dot products: det = e1.pv, u = tv.pv, v = dir.qv, t = e2.qv
  always_comb begin
    logic signed [EW-1:0]   av;
    logic signed [XW-1:0]   bv;
    logic signed [LW:0]     lo;
    logic signed [HW-1:0]   hi;
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 3; i++) begin
        case (d)
          0:       begin av = b3_e1_r[i];     bv = cr_r[0][i]; end
          1:       begin av = b3_tv_r[i];     bv = cr_r[0][i]; end
          2:       begin av = EW'(dir_r[i]);  bv = cr_r[1][i]; end
          default: begin av = b3_e2_r[i];     bv = cr_r[1][i]; end
        endcase
        lo = signed'({1'b0, bv[LW-1:0]});
        hi = bv[XW-1:LW];
        pl_nxt[d][i] = av * lo;
        ph_nxt[d][i] = av * hi;
        pr_nxt[d][i] = (DW'(ph_r[d][i]) <<< LW) + DW'(pl_r[d][i]);
      end
      s_nxt[d] = pr_r[d][0] + pr_r[d][1] + pr_r[d][2];
    end
  end

  // outcome decision
  always_comb begin
    logic signed [DW:0] uv;
    uv = (DW+1)'(s_r[1]) + (DW+1)'(s_r[2]);
    if (s_r[0] < signed'(rti_pkg::EPS_LIM)) begin
      oc_nxt = rti_pkg::OUT_CULL;
    end else if (s_r[1][DW-1] || (s_r[1] > s_r[0])) begin
      oc_nxt = rti_pkg::OUT_U;
    end else if (s_r[2][DW-1] || (uv > (DW+1)'(s_r[0]))) begin
      oc_nxt = rti_pkg::OUT_V;
    end else if (s_r[3][DW-1]) begin
      oc_nxt = rti_pkg::OUT_BEHIND;
    end else begin
      oc_nxt = rti_pkg::OUT_HIT;
    end
  end

  // distance divide pipeline
  rti_pkg::dv_t  dv_r   [0:QW];
  rti_pkg::dv_t  dv_nxt [0:QW];
  logic [QW:0]   dvv_r;

  always_comb begin
    logic [rti_pkg::NW-1:0] num;
    logic [rti_pkg::CW-1:0] dsh;
    num = {t_r, {F{1'b0}}};
    dsh = rti_pkg::CW'(det_r) << QW;
    dv_nxt[0].oc  = oc_r;
    dv_nxt[0].q   = '0;
    dv_nxt[0].rem = num;
    dv_nxt[0].den = det_r;
    dv_nxt[0].sat = rti_pkg::CW'(num) >= dsh;
    for (int j = 1; j <= QW; j++) begin
      dv_nxt[j] = dv_r[j-1];
      dsh = rti_pkg::CW'(dv_r[j-1].den) << (QW - j);
      if (rti_pkg::CW'(dv_r[j-1].rem) >= dsh) begin
        dv_nxt[j].rem = rti_pkg::NW'(rti_pkg::CW'(dv_r[j-1].rem) - dsh);
        dv_nxt[j].q[QW-j] = 1'b1;
      end
    end
  end

  logic [QW-1:0]              res_dist;
  logic [rti_pkg::OUT_TW-1:0] res_data;
  logic                       res_v;

  always_comb begin
    if (dv_r[QW].oc == rti_pkg::OUT_HIT) begin
      res_dist = dv_r[QW].sat ? rti_pkg::QMAX : dv_r[QW].q;
    end else begin
      res_dist = '0;
    end
    res_data = {{(rti_pkg::OUT_TW-rti_pkg::OUT_BITS){1'b0}}, res_dist, dv_r[QW].oc};
    res_v    = dvv_r[QW];
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdv_r <= '0;
      dvv_r <= '0;
      {b1v_r, b2v_r, b3v_r, b4v_r, b5v_r, b6v_r, b7v_r} <= '0;
    end else if (en) begin
      vdv_r <= {vdv_r[QW-1:0], in_tvalid};
      b1v_r <= vdv_r[QW];
      b2v_r <= b1v_r;
      b3v_r <= b2v_r;
      b4v_r <= b3v_r;
      b5v_r <= b4v_r;
      b6v_r <= b5v_r;
      b7v_r <= b6v_r;
      dvv_r <= {dvv_r[QW-1:0], b7v_r};
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j <= QW; j++) begin
        vd_r[j] <= vd_nxt[j];
        dv_r[j] <= dv_nxt[j];
      end
      b1_e1_r <= b1_e1_nxt;
      b1_e2_r <= b1_e2_nxt;
      b1_tv_r <= b1_tv_nxt;
      b2_e1_r <= b1_e1_r;
      b2_e2_r <= b1_e2_r;
      b2_tv_r <= b1_tv_r;
      b3_e1_r <= b2_e1_r;
      b3_e2_r <= b2_e2_r;
      b3_tv_r <= b2_tv_r;
      px_r    <= px_nxt;
      cr_r    <= cr_nxt;
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      pr_r    <= pr_nxt;
      s_r     <= s_nxt;
      oc_r    <= oc_nxt;
      t_r     <= s_r[3];
      det_r   <= s_r[0];
    end
  end

  // output register and skid
  logic                       out_v_r, skid_v_r;
  logic [rti_pkg::OUT_TW-1:0] out_d_r, skid_d_r;

  assign en         = !skid_v_r;
  assign in_tready  = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= res_v;
      end
    end else if (res_v && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_d_r <= skid_v_r ? skid_d_r : res_data;
    end else if (res_v && en) begin
      skid_d_r <= res_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds an item while output is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled without a stalled output");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[2:0] != rti_pkg::OUT_HIT)) |-> (out_tdata[QW+2:3] == '0))
    else $error("non-zero distance on a miss");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= rti_pkg::OUT_BEHIND))
    else $error("outcome code out of range");

endmodule

// ===== sim/ray_triangle_intersect_core_tb.sv =====
module ray_triangle_intersect_core_tb;

  localparam int VW = 4 * rti_pkg::COORD_WIDTH - 1;
  localparam logic [rti_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [rti_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef logic signed [191:0] wide_t;
  typedef wide_t vec_t [3];

  typedef struct {
    logic [31:0] x [3];
    logic [31:0] y [3];
    logic [31:0] z [3];
    logic [30:0] w [3];
  } tri_t;

  class hit_scoreboard;
    logic [31:0] ray [6];
    rti_pkg::outcome_t exp_oc [$];
    logic [30:0] exp_dist [$];
    int errors;

    function new();
      foreach (ray[i]) ray[i] = '0;
      ray[rti_pkg::REG_DIR_Z] = rti_pkg::DIR_Z_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [rti_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx <= rti_pkg::REG_DIR_Z) ray[idx] = val;
    endfunction

    function wide_t to_cart(logic [31:0] c, logic [30:0] w);
      longint unsigned mag, wd, q;
      mag = c[31] ? (64'h1_0000_0000 - 64'(c)) : 64'(c);
      wd = (w == 0) ? 64'd1 : 64'(w);
      q = (mag << rti_pkg::FRAC_BITS) / wd;
      if (q > 64'(rti_pkg::QMAX)) q = 64'(rti_pkg::QMAX);
      return c[31] ? -wide_t'(q) : wide_t'(q);
    endfunction

    function vec_t cross_prod(vec_t a, vec_t b);
      vec_t r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
    endfunction

    function wide_t dot(vec_t a, vec_t b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function void note_triangle(logic [rti_pkg::IN_TW-1:0] d);
      vec_t p [3];
      vec_t e1, e2, org, dir, tv, pv, qv;
      wide_t det, uu, vv, tt, quo;
      rti_pkg::outcome_t oc;
      logic [30:0] exp_d;
      for (int k = 0; k < 3; k++) begin
        p[k][0] = to_cart(d[k*VW +: 32], d[k*VW+96 +: 31]);
        p[k][1] = to_cart(d[k*VW+32 +: 32], d[k*VW+96 +: 31]);
        p[k][2] = to_cart(d[k*VW+64 +: 32], d[k*VW+96 +: 31]);
      end
      for (int i = 0; i < 3; i++) begin
        org[i] = wide_t'($signed(ray[i]));
        dir[i] = wide_t'($signed(ray[3+i]));
        e1[i] = p[1][i] - p[0][i];
        e2[i] = p[2][i] - p[0][i];
        tv[i] = org[i] - p[0][i];
      end
      oc = rti_pkg::OUT_HIT;
      exp_d = '0;
      pv = cross_prod(dir, e2);
      det = dot(e1, pv);
      if (det * wide_t'(1000000) < (wide_t'(1) <<< (3 * rti_pkg::FRAC_BITS))) begin
        oc = rti_pkg::OUT_CULL;
      end else begin
        uu = dot(tv, pv);
        if (uu < 0 || uu > det) begin
          oc = rti_pkg::OUT_U;
        end else begin
          qv = cross_prod(tv, e1);
          vv = dot(dir, qv);
          if (vv < 0 || uu + vv > det) begin
            oc = rti_pkg::OUT_V;
          end else begin
            tt = dot(e2, qv);
            if (tt < 0) begin
              oc = rti_pkg::OUT_BEHIND;
            end else begin
              quo = (tt <<< rti_pkg::FRAC_BITS) / det;
              exp_d = (quo > wide_t'(rti_pkg::QMAX)) ? rti_pkg::QMAX : quo[30:0];
            end
          end
        end
      end
      exp_oc = {exp_oc, oc};
      exp_dist = {exp_dist, exp_d};
    endfunction

    function void check_result(logic [rti_pkg::OUT_TW-1:0] d);
      rti_pkg::outcome_t oc;
      logic [30:0] exp_d;
      if (exp_oc.size() == 0) begin
        $error("unexpected result item outcome=%0d distance=%0d", d[2:0], d[33:3]);
        errors++;
        return;
      end
      oc = exp_oc.pop_front();
      exp_d = exp_dist.pop_front();
      if (d[2:0] !== oc) begin
        $error("outcome expected %0d actual %0d", oc, d[2:0]);
        errors++;
      end
      if (d[33:3] !== exp_d) begin
        $error("distance expected %0d actual %0d", exp_d, d[33:3]);
        errors++;
      end
    endfunction

    function int pending();
      return exp_oc.size();
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [rti_pkg::REG_IDX_W-1:0] cfg_index;
  logic [rti_pkg::COORD_WIDTH-1:0] cfg_wdata;
  logic in_tvalid, in_tready;
  logic [rti_pkg::IN_TW-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [rti_pkg::OUT_TW-1:0] out_tdata;

  hit_scoreboard sb;
  bit long_hold;
  int unsigned stall_pct;
  logic [31:0] org_now [3];

  ray_triangle_intersect_core uut (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_triangle(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [rti_pkg::IN_TW-1:0] pack_tri(tri_t t);
    logic [rti_pkg::IN_TW-1:0] d;
    d = '0;
    for (int k = 0; k < 3; k++) begin
      d[k*VW +: 32] = t.x[k];
      d[k*VW+32 +: 32] = t.y[k];
      d[k*VW+64 +: 32] = t.z[k];
      d[k*VW+96 +: 31] = t.w[k];
    end
    return d;
  endfunction

  task automatic send_tri(tri_t t);
    @(negedge clk);
    in_tdata <= pack_tri(t);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    pause_sender(0);
    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_ray(logic [31:0] v [6]);
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= rti_pkg::REG_IDX_W'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      sb.set_reg(rti_pkg::REG_IDX_W'(i), v[i]);
      if (i < 3) org_now[i] = v[i];
    end
    @(negedge clk);
    cfg_index <= REG_SPARE_A;
    cfg_wdata <= $urandom;
    @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_SPARE_B;
    cfg_wdata <= $urandom;
    @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tri_t make_tri(int mode);
    tri_t t;
    int signed cx, cy, cz;
    cx = $signed(org_now[0]) >>> 1;
    cy = $signed(org_now[1]) >>> 1;
    cz = $signed(org_now[2]) >>> 1;
    for (int k = 0; k < 3; k++) begin
      if (mode == 0) begin
        t.x[k] = $urandom;
        t.y[k] = $urandom;
        t.z[k] = $urandom;
        t.w[k] = 31'($urandom);
      end else begin
        t.x[k] = cx + $signed($urandom_range(8 << 16)) - (4 << 16);
        t.y[k] = cy + $signed($urandom_range(8 << 16)) - (4 << 16);
        t.z[k] = cz + $signed($urandom_range(40 << 16)) - (20 << 16);
        t.w[k] = ($urandom_range(9) == 0) ? 31'($urandom_range(4 << 16, 1)) : 31'(1 << 16);
        if (t.w[k] != (1 << 16)) begin
          t.x[k] = 32'($signed(t.x[k]) >>> 2);
          t.y[k] = 32'($signed(t.y[k]) >>> 2);
          t.z[k] = 32'($signed(t.z[k]) >>> 2);
        end
      end
    end
    return t;
  endfunction

  task automatic random_part(int n, bit hold_at_middle);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(30, 1);
      for (int b = 0; b < burst && sent < n; b++) begin
        send_tri(make_tri(($urandom_range(9) < 8) ? 1 : 0));
        sent++;
        if (hold_at_middle && sent == n / 2) long_hold = 1;
      end
      if ($urandom_range(3) != 0) pause_sender($urandom_range(12));
    end
  endtask

  function automatic tri_t flat_tri(int signed ax, int signed ay, int signed bx, int signed by,
                                    int signed qx, int signed qy, int signed zz);
    tri_t t;
    t.x[0] = ax; t.y[0] = ay;
    t.x[1] = bx; t.y[1] = by;
    t.x[2] = qx; t.y[2] = qy;
    for (int k = 0; k < 3; k++) begin
      t.z[k] = zz;
      t.w[k] = 31'(1 << 16);
    end
    return t;
  endfunction

  initial begin
    logic [31:0] rv [6];
    tri_t t;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    long_hold = 0;
    stall_pct = 0;
    foreach (org_now[i]) org_now[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed triangles with the reset ray along +z
    send_tri(flat_tri(-65536, -65536, 0, 65536, 65536, -65536, 5 << 16));
    send_tri(flat_tri(-65536, -65536, 65536, -65536, 0, 65536, 5 << 16));
    send_tri(flat_tri(-65536, -65536, 0, 65536, 65536, -65536, -(5 << 16)));
    send_tri(flat_tri(0, 0, 0, 65536, 65536, 0, 0));
    send_tri(flat_tri(0, -65536, 65536, 65536, 65536, -65536, 3 << 16));
    send_tri(flat_tri(-65536, 0, -65536, 65536, 0, 0, 3 << 16));
    send_tri(flat_tri(-65536, 65536, 0, 65536, 65536, 0, 3 << 16));
    send_tri(flat_tri(3 << 16, 3 << 16, 3 << 16, 4 << 16, 4 << 16, 3 << 16, 1 << 16));
    send_tri(flat_tri(0, 0, 0, 0, 0, 0, 1 << 16));
    send_tri(flat_tri(-65536, -65536, 0, 65536, 65536, -65536, 32'h7fff_ffff));
    send_tri(flat_tri(-2, -2, 0, 2, 2, -2, 1));
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 3; k++) begin
        t.x[k] = m[0] ? 32'h7fff_ffff : 32'h8000_0000;
        t.y[k] = (m[1] ^ k[0]) ? 32'h7fff_ffff : 32'h8000_0000;
        t.z[k] = (k == 1) ? 32'h7fff_ffff : 32'h8000_0000;
        t.w[k] = (m == 0) ? 31'd0 : (m == 1) ? 31'd1 : (m == 2) ? 31'h7fff_ffff : 31'(k);
      end
      send_tri(t);
    end
    t = flat_tri(-65536, -65536, 0, 65536, 65536, -65536, 5 << 16);
    t.w[0] = 31'd0; t.w[1] = 31'h7fff_ffff; t.w[2] = 31'(2 << 16);
    send_tri(t);
    t = flat_tri(-(2 << 16), -(2 << 16), 0, 2 << 16, 2 << 16, -(2 << 16), 8 << 16);
    for (int k = 0; k < 3; k++) t.w[k] = 31'(2 << 16);
    send_tri(t);

    stall_pct = 30;
    random_part(200, 1);
    drain();

    rv[0] = 32'h0000_8000; rv[1] = 32'h0000_4000; rv[2] = 32'hfffd_0000;
    rv[3] = 32'h0000_028f; rv[4] = 32'hffff_fae1; rv[5] = 32'h0001_0000;
    load_ray(rv);
    stall_pct = 0;
    random_part(200, 0);
    drain();

    rv[0] = 32'h7fff_ffff; rv[1] = 32'h8000_0000; rv[2] = 32'h7fff_ffff;
    rv[3] = 32'h8000_0000; rv[4] = 32'h7fff_ffff; rv[5] = 32'h8000_0000;
    load_ray(rv);
    stall_pct = 60;
    random_part(120, 0);
    drain();

    rv[0] = 32'h0000_0000; rv[1] = 32'h0000_0000; rv[2] = 32'h0064_0000;
    rv[3] = 32'h0000_0001; rv[4] = 32'hffff_ffff; rv[5] = 32'hffff_0000;
    load_ray(rv);
    stall_pct = 20;
    random_part(260, 1);
    drain();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
